// File: rtl/core/mlc_pkg.sv
// Shared widths, token class codes and item types for the markup line classifier.
`default_nettype none

package mlc_pkg;

  localparam int LINE_COUNT_BITS = 24;
  localparam int LENGTH_BITS     = 16;
  localparam int BYTE_BITS       = 8;
  localparam int CLASS_BITS      = 4;
  localparam int LEVEL_BITS      = 3;

  localparam logic [CLASS_BITS-1:0] CLS_BLANK       = 4'd0;
  localparam logic [CLASS_BITS-1:0] CLS_HEADING     = 4'd1;
  localparam logic [CLASS_BITS-1:0] CLS_CODE_START  = 4'd2;
  localparam logic [CLASS_BITS-1:0] CLS_CODE_END    = 4'd3;
  localparam logic [CLASS_BITS-1:0] CLS_QUOTE_START = 4'd4;
  localparam logic [CLASS_BITS-1:0] CLS_QUOTE_END   = 4'd5;
  localparam logic [CLASS_BITS-1:0] CLS_META        = 4'd6;
  localparam logic [CLASS_BITS-1:0] CLS_LIST        = 4'd7;
  localparam logic [CLASS_BITS-1:0] CLS_TEXT        = 4'd8;
  localparam logic [CLASS_BITS-1:0] CLS_END         = 4'd9;

  // One input request as held in the input register.
  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 is_end;
  } in_item_t;

  // One result token.
  typedef struct packed {
    logic                       last_of_run;
    logic [LENGTH_BITS-1:0]     text_offset;
    logic [LENGTH_BITS-1:0]     line_length;
    logic [LINE_COUNT_BITS-1:0] line_number;
    logic [LEVEL_BITS-1:0]      heading_level;
    logic [CLASS_BITS-1:0]      token_class;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/mlc_in_reg.sv
// Input register stage that captures one byte request per cycle while it is free.
`default_nettype none

module mlc_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,
  input  wire logic              s_tlast,
  output logic                   item_valid,
  output mlc_pkg::in_item_t      item,
  input  wire logic              consume
);
  import mlc_pkg::*;

  // The register is free when empty or when its request is used up this cycle.
  assign s_tready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.data   <= s_tdata;
      item.is_end <= s_tlast;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mlc_line_tracker.sv
// Per-line flag tracking and line classification for one request per cycle while the result queue has room.
`default_nettype none

module mlc_line_tracker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire mlc_pkg::in_item_t item,
  input  wire logic              can_push,
  output logic                   consume,
  output logic                   push,
  output mlc_pkg::result_t       res
);
  import mlc_pkg::*;

  localparam int PREFIX_COUNT = 4;
  localparam int MAX_STARS    = 6;
  localparam int PFX_BITS     = 104;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [1:0] LIST_LEAD = 2'd0;
  localparam logic [1:0] LIST_YES  = 2'd1;
  localparam logic [1:0] LIST_NO   = 2'd2;

  // Prefix strings are right-justified: the last character sits in the low byte.
  localparam logic [PFX_BITS-1:0] PFX_SRC_BEGIN   = PFX_BITS'({"#+begin", "_src"});
  localparam logic [PFX_BITS-1:0] PFX_SRC_END     = PFX_BITS'({"#+end", "_src"});
  localparam logic [PFX_BITS-1:0] PFX_QUOTE_BEGIN = PFX_BITS'({"#+begin", "_quote"});
  localparam logic [PFX_BITS-1:0] PFX_QUOTE_END   = PFX_BITS'({"#+end", "_quote"});
  localparam logic [PREFIX_COUNT-1:0][3:0] PFX_LEN = {4'd11, 4'd13, 4'd9, 4'd11};

  typedef struct packed {
    logic [LENGTH_BITS-1:0]  byte_position;
    logic [2:0]              star_run;
    logic                    heading_ok;
    logic [PREFIX_COUNT-1:0] prefix_alive;
    logic                    colon_seen;
    logic [1:0]              list_phase;
    logic                    held_return;
    logic                    hash_plus;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{prefix_alive: '1, default: '0};

  function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [3:0] i);
    logic [PFX_BITS-1:0] txt;
    logic [3:0]          sh;
    case (k)
      2'd0:    txt = PFX_SRC_BEGIN;
      2'd1:    txt = PFX_SRC_END;
      2'd2:    txt = PFX_QUOTE_BEGIN;
      default: txt = PFX_QUOTE_END;
    endcase
    sh = PFX_LEN[k] - 4'd1 - i;
    return txt[{sh, 3'b000} +: 8];
  endfunction

  function automatic line_state_t feed(input line_state_t s, input logic [7:0] c);
    line_state_t n;
    n = s;
    if (s.byte_position == {{(LENGTH_BITS-3){1'b0}}, s.star_run}) begin
      if (c == CH_STAR && s.star_run < 3'(MAX_STARS + 1)) begin
        n.star_run = s.star_run + 3'd1;
      end else begin
        n.heading_ok = (s.star_run >= 3'd1) && (s.star_run <= 3'(MAX_STARS)) &&
                       (c == CH_SPACE);
      end
    end
    for (int k = 0; k < PREFIX_COUNT; k++) begin
      if (s.byte_position < LENGTH_BITS'(PFX_LEN[k]) &&
          c != prefix_char(2'(k), s.byte_position[3:0])) begin
        n.prefix_alive[k] = 1'b0;
      end
    end
    if (s.byte_position == '0) begin
      n.hash_plus = (c == CH_HASH);
    end else if (s.byte_position == LENGTH_BITS'(1)) begin
      n.hash_plus = s.hash_plus && (c == CH_PLUS);
    end
    if (c == CH_COLON) begin
      n.colon_seen = 1'b1;
    end
    if (s.list_phase == LIST_LEAD && c != CH_SPACE) begin
      n.list_phase = (c == CH_DASH || (c >= CH_ZERO && c <= CH_NINE)) ? LIST_YES : LIST_NO;
    end
    if (s.byte_position != '1) begin
      n.byte_position = s.byte_position + LENGTH_BITS'(1);
    end
    return n;
  endfunction

  line_state_t                st, st_next, fed_cr, fed_byte;
  logic [LINE_COUNT_BITS-1:0] line_count, line_count_next, count_inc;
  logic [CLASS_BITS-1:0]      fin_class;
  logic [LEVEL_BITS-1:0]      fin_level;
  logic [LENGTH_BITS-1:0]     fin_offset;
  logic                       star_ok, star_eq, pending, advance;
  logic [PREFIX_COUNT-1:0]    pfx_hit;

  assign advance   = item_valid && can_push;
  assign pending   = (st.byte_position != '0) || st.held_return;
  assign count_inc = (line_count != '1) ? line_count + LINE_COUNT_BITS'(1) : line_count;

  // Classification of the line collected so far.
  always_comb begin
    star_ok = (st.star_run >= 3'd1) && (st.star_run <= 3'(MAX_STARS));
    star_eq = st.byte_position == {{(LENGTH_BITS-3){1'b0}}, st.star_run};
    for (int k = 0; k < PREFIX_COUNT; k++) begin
      pfx_hit[k] = st.prefix_alive[k] && (st.byte_position >= LENGTH_BITS'(PFX_LEN[k]));
    end
    fin_level  = '0;
    fin_offset = '0;
    if (st.byte_position == '0) begin
      fin_class = CLS_BLANK;
    end else if (star_ok && (st.heading_ok || star_eq)) begin
      fin_class  = CLS_HEADING;
      fin_level  = st.star_run;
      fin_offset = star_eq ? st.byte_position
                           : {{(LENGTH_BITS-3){1'b0}}, st.star_run} + LENGTH_BITS'(1);
    end else if (pfx_hit[0]) begin
      fin_class = CLS_CODE_START;
    end else if (pfx_hit[1]) begin
      fin_class = CLS_CODE_END;
    end else if (pfx_hit[2]) begin
      fin_class = CLS_QUOTE_START;
    end else if (pfx_hit[3]) begin
      fin_class = CLS_QUOTE_END;
    end else if (st.byte_position > LENGTH_BITS'(2) && st.hash_plus && st.colon_seen) begin
      fin_class = CLS_META;
    end else if (st.list_phase == LIST_YES) begin
      fin_class = CLS_LIST;
    end else begin
      fin_class = CLS_TEXT;
    end
  end

  // A held CR becomes an ordinary byte when anything but a line end follows it.
  always_comb begin
    fed_cr = st;
    if (st.held_return) begin
      fed_cr.held_return = 1'b0;
      fed_cr = feed(fed_cr, CH_CR);
    end
    if (item.data == CH_CR) begin
      fed_byte = fed_cr;
      fed_byte.held_return = 1'b1;
    end else begin
      fed_byte = feed(fed_cr, item.data);
    end
  end

  always_comb begin
    st_next         = st;
    line_count_next = line_count;
    push            = 1'b0;
    consume         = 1'b0;
    res.token_class   = fin_class;
    res.heading_level = fin_level;
    res.line_number   = count_inc;
    res.line_length   = st.byte_position;
    res.text_offset   = fin_offset;
    res.last_of_run   = 1'b1;
    if (advance) begin
      if (item.is_end) begin
        push    = 1'b1;
        st_next = LINE_CLEAR;
        if (pending) begin
          // Flush the partial line; the end request stays in place and then yields the end token.
          res.last_of_run = 1'b0;
          line_count_next = count_inc;
        end else begin
          consume = 1'b1;
          res.token_class   = CLS_END;
          res.heading_level = '0;
          res.line_number   = line_count;
          res.line_length   = '0;
          res.text_offset   = '0;
        end
      end else if (item.data == CH_NL) begin
        push            = 1'b1;
        consume         = 1'b1;
        st_next         = LINE_CLEAR;
        line_count_next = count_inc;
      end else begin
        consume = 1'b1;
        st_next = fed_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= LINE_CLEAR;
      line_count <= '0;
    end else begin
      st         <= st_next;
      line_count <= line_count_next;
    end
  end

  // An end token always leaves a clean line behind it.
  assert property (@(posedge clk) disable iff (rst)
    (push && res.token_class == CLS_END) |=> (st.byte_position == '0 && !st.held_return))
    else $error("line state not cleared after end token");

  // A flushed partial line keeps the end request in place for the token.
  assert property (@(posedge clk) disable iff (rst)
    (push && !res.last_of_run) |=> (item_valid && item.is_end))
    else $error("end request lost after flushing a partial line");

endmodule

`default_nettype wire

// File: rtl/core/mlc_out_fifo.sv
// Two-entry result queue that decouples the classifier from the output handshake.
`default_nettype none

module mlc_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire mlc_pkg::result_t  wr_data,
  output logic                   can_push,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [63:0]            m_tdata,
  output logic                   m_tlast
);
  import mlc_pkg::*;

  result_t    entries [2];
  logic       wr_ptr, rd_ptr, pop;
  logic [1:0] count;
  result_t    head;

  assign can_push = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign head     = entries[rd_ptr];
  assign m_tdata  = {1'b0, head.text_offset, head.line_length, head.line_number,
                     head.heading_level, head.token_class};
  assign m_tlast  = head.last_of_run;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> can_push)
    else $error("result written into a full queue");

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not follow a write");

endmodule

`default_nettype wire

// File: rtl/core/markup_line_classifier.sv
// Top level of the markup line classifier: byte stream in, line tokens out.
//
//   Channel  Direction  Payload                                        Marker
//   s_*      in         tdata[7:0] byte_in                             tlast = is_end
//   m_*      out        tdata: class, level, line, length, offset      tlast = last_of_run
//
// Each byte request is registered on entry and then handled by the line tracker,
// so one request is taken per cycle while the result queue has room.
// A newline yields one token; an end request on a pending line yields two tokens,
// the end request staying in the input register meanwhile.
// Reset clears the line state and counter and empties the input register.
// Output stalls fill the two-entry result queue, after which the input register
// holds and s_tready falls; no token is dropped or repeated.
`default_nettype none

module markup_line_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
  input  wire logic        s_tlast,   // is_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [3:0] token_class, [6:4] heading_level,
                                      // [30:7] line_number, [46:31] line_length,
                                      // [62:47] text_offset, [63] zero
  output logic             m_tlast    // last_of_run
);
  import mlc_pkg::*;

  in_item_t item;
  result_t  res;
  logic     item_valid, consume, push, can_push;

  // Input register: holds one byte request until the tracker takes it.
  mlc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (item_valid),
    .item       (item),
    .consume    (consume)
  );

  // Line tracker: updates the per-line flags and builds a token at each line end.
  mlc_line_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .can_push   (can_push),
    .consume    (consume),
    .push       (push),
    .res        (res)
  );

  // Result queue: keeps the tracker running while the output side stalls.
  mlc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (res),
    .can_push (can_push),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the markup line classifier: byte stream in, line tokens out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlc_pkg::*;

  // Run-level constants. The hard limit sits far above the longest run, with
  // both sides idling at their worst in the random phases.
  localparam int  TIMEOUT_NS    = 20_000_000;
  localparam int  SETTLE_CYCLES = 16;
  localparam int  HDR_MAX       = 6;
  localparam int  MAX_REPORTS   = 100;
  localparam int  PHASE_ITEMS   = 450;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Leading parts of the block markers.
  localparam string KW_OPEN  = "#+begin";
  localparam string KW_CLOSE = "#+end";

  // Where the line stands with respect to its first non-space byte.
  typedef enum logic [1:0] {LEAD_SPACES, LEAD_LIST, LEAD_OTHER} lead_t;

  // One token laid out exactly as {m_tlast, m_tdata}, so a whole compare is one
  // vector compare and the spare top bit of tdata is checked to be zero.
  typedef struct packed {
    logic                       last;
    logic                       pad;
    logic [LENGTH_BITS-1:0]     offset;
    logic [LENGTH_BITS-1:0]     length;
    logic [LINE_COUNT_BITS-1:0] line_no;
    logic [LEVEL_BITS-1:0]      level;
    logic [CLASS_BITS-1:0]      cls;
  } token_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;

  markup_line_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Block-marker prefixes, checked in this order, and the class each one gives.
  string                 pfx_txt [4] = '{{KW_OPEN, "_src"}, {KW_CLOSE, "_src"},
                                         {KW_OPEN, "_quote"}, {KW_CLOSE, "_quote"}};
  logic [CLASS_BITS-1:0] pfx_cls [4] = '{CLS_CODE_START, CLS_CODE_END,
                                         CLS_QUOTE_START, CLS_QUOTE_END};

  // Line tracker mirror. Everything is per line except the line counter.
  logic [LINE_COUNT_BITS-1:0] lines_seen = '0;
  logic [LENGTH_BITS-1:0]     col        = '0;
  logic [2:0]                 stars      = '0;
  logic                       star_hdr   = 1'b0;
  logic [3:0]                 pfx_live   = 4'hF;
  logic                       has_colon  = 1'b0;
  lead_t                      lead       = LEAD_SPACES;
  logic                       cr_held    = 1'b0;
  logic                       hash_plus  = 1'b0;

  token_t tok_q[$];          // tokens still owed by the block, oldest first
  int     err_cnt        = 0;
  int     sent           = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  function automatic void clear_line();
    col       = '0;
    stars     = '0;
    star_hdr  = 1'b0;
    pfx_live  = 4'hF;
    has_colon = 1'b0;
    lead      = LEAD_SPACES;
    cr_held   = 1'b0;
    hash_plus = 1'b0;
  endfunction

  // Folds one byte of line content into the classification flags.
  function automatic void take_char(input logic [7:0] c);
    // The star run is only tracked while every byte so far has been a star.
    if (int'(col) == int'(stars)) begin
      if (c == CH_STAR && stars < 3'd7)
        stars++;
      else
        star_hdr = (stars >= 1 && stars <= HDR_MAX && c == CH_SPACE);
    end
    for (int k = 0; k < 4; k++) begin
      if (col < pfx_txt[k].len() && c != pfx_txt[k][col])
        pfx_live[k] = 1'b0;
    end
    if (col == 0)
      hash_plus = (c == CH_HASH);
    else if (col == 1)
      hash_plus = hash_plus && (c == CH_PLUS);
    if (c == CH_COLON)
      has_colon = 1'b1;
    if (lead == LEAD_SPACES && c != CH_SPACE)
      lead = (c == CH_DASH || (c >= CH_ZERO && c <= 8'h39)) ? LEAD_LIST : LEAD_OTHER;
    if (col != '1)
      col++;
  endfunction

  // Classifies the line collected so far and queues its token.
  function automatic void close_line(input logic last);
    token_t t;
    logic   found;
    t     = '0;
    found = 1'b0;
    if (lines_seen != '1)
      lines_seen++;
    t.cls = CLS_TEXT;
    if (col == 0) begin
      t.cls = CLS_BLANK;
    end else if (stars >= 1 && stars <= HDR_MAX &&
                 (star_hdr || int'(col) == int'(stars))) begin
      // A line of stars alone points its text at the line end.
      t.cls    = CLS_HEADING;
      t.level  = stars;
      t.offset = (int'(col) == int'(stars)) ? col
                                            : LENGTH_BITS'(stars) + LENGTH_BITS'(1);
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (!found && pfx_live[k] && col >= pfx_txt[k].len()) begin
          t.cls = pfx_cls[k];
          found = 1'b1;
        end
      end
      if (!found) begin
        if (col > 2 && hash_plus && has_colon)
          t.cls = CLS_META;
        else if (lead == LEAD_LIST)
          t.cls = CLS_LIST;
      end
    end
    t.line_no = lines_seen;
    t.length  = col;
    t.last    = last;
    tok_q.push_back(t);
    clear_line();
  endfunction

  // Expected tokens for one accepted request.
  function automatic void predict_request(input logic [7:0] b, input logic e);
    token_t t;
    if (e) begin
      // End of input flushes a partial line, a lone held CR included.
      if (col != 0 || cr_held)
        close_line(1'b0);
      t         = '0;
      t.cls     = CLS_END;
      t.line_no = lines_seen;
      t.last    = 1'b1;
      tok_q.push_back(t);
      clear_line();
    end else if (b == CH_NL) begin
      close_line(1'b1);
    end else begin
      // A CR only turns into line content once a byte other than a line end follows.
      if (cr_held) begin
        cr_held = 1'b0;
        take_char(CH_CR);
      end
      if (b == CH_CR)
        cr_held = 1'b1;
      else
        take_char(b);
    end
  endfunction

  // The receiver stalls at the rate set for the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted token is matched against the oldest one owed.
  always @(posedge clk) begin : token_check
    token_t want;
    token_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata};
      if (tok_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected token: expected none, actual cls=%0d lvl=%0d line=%0d len=%0d off=%0d last=%0d pad=%0d",
                   $time, got.cls, got.level, got.line_no, got.length, got.offset,
                   got.last, got.pad);
      end else begin
        want = tok_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: token mismatch: expected cls=%0d lvl=%0d line=%0d len=%0d off=%0d last=%0d pad=%0d, actual cls=%0d lvl=%0d line=%0d len=%0d off=%0d last=%0d pad=%0d",
                     $time, want.cls, want.level, want.line_no, want.length, want.offset,
                     want.last, want.pad, got.cls, got.level, got.line_no, got.length,
                     got.offset, got.last, got.pad);
        end
      end
    end
  end

  // Sends one request. Idle cycles carry junk on the data lines so that the block
  // is seen to ignore them. Valid is left high on return, so a request that
  // follows straight away keeps the bus busy without a gap.
  task automatic send_req(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= e;
    do @(posedge clk); while (!s_tready);
    predict_request(b, e);
    sent++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++)
      send_req(s[i], 1'b0);
    send_req(CH_NL, 1'b0);
  endtask

  // End of input; the byte lane is a don't-care then, so it carries noise.
  task automatic send_end();
    send_req(8'($urandom), 1'b1);
  endtask

  // Lets the block drain: valid drops until every owed token has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tok_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random line content, weighted toward the bytes that move the flags.
  task automatic send_tail(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0:       b = CH_SPACE;
        1:       b = CH_COLON;
        2:       b = CH_STAR;
        3:       b = CH_CR;
        4:       b = 8'($urandom);
        default: b = 8'($urandom_range(33, 126));
      endcase
      send_req(b, 1'b0);
    end
  endtask

  // One mostly well-formed line of a random kind, then a random terminator.
  task automatic send_rand_line();
    string p;
    int    cut;
    int    flip;
    case ($urandom_range(0, 9))
      0: ;  // blank line
      1: begin
        // Star runs from one to past the heading limit, with or without a space.
        repeat ($urandom_range(1, 8)) send_req(CH_STAR, 1'b0);
        if ($urandom_range(1)) begin
          send_req($urandom_range(1) ? CH_SPACE : 8'($urandom_range(33, 126)), 1'b0);
          send_tail($urandom_range(0, 8));
        end
      end
      2: begin
        // Block markers, sometimes cut short or with one byte spoiled.
        p    = pfx_txt[$urandom_range(0, 3)];
        cut  = $urandom_range(p.len() - 2, p.len());
        flip = $urandom_range(0, 2 * p.len());
        for (int i = 0; i < cut; i++)
          send_req((i == flip) ? 8'($urandom_range(33, 126)) : p[i], 1'b0);
        send_tail($urandom_range(0, 6));
      end
      3: begin
        send_req(CH_HASH, 1'b0);
        send_req($urandom_range(3) ? CH_PLUS : CH_HASH, 1'b0);
        send_tail($urandom_range(0, 3));
        if ($urandom_range(3))
          send_req(CH_COLON, 1'b0);
        send_tail($urandom_range(0, 6));
      end
      4: begin
        repeat ($urandom_range(0, 3)) send_req(CH_SPACE, 1'b0);
        send_req($urandom_range(1) ? CH_DASH : CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        send_tail($urandom_range(0, 8));
      end
      5: begin
        repeat ($urandom_range(1, 4)) send_req(CH_SPACE, 1'b0);
        send_tail($urandom_range(0, 8));
      end
      6: begin
        // Raw noise over the whole byte range.
        repeat ($urandom_range(1, 12)) send_req(8'($urandom), 1'b0);
      end
      default: send_tail($urandom_range(0, 16));
    endcase
    case ($urandom_range(0, 19))
      0: send_end();
      1: begin
        send_req(CH_CR, 1'b0);
        send_end();
      end
      2, 3: begin
        send_req(CH_CR, 1'b0);
        send_req(CH_NL, 1'b0);
      end
      default: send_req(CH_NL, 1'b0);
    endcase
  endtask

  // End of input with nothing pending, with a partial line, and with only a CR.
  task automatic test_end_of_input();
    send_end();
    send_req(8'h78, 1'b0);
    send_req(8'h79, 1'b0);
    send_end();
    send_req(CH_CR, 1'b0);
    send_end();
    send_line("- a");
    send_req(CH_DASH, 1'b0);
    send_end();
  endtask

  // One line of every class, plus the near misses around each rule.
  task automatic test_line_classes();
    send_line("");
    send_line("* a");
    send_line("******");
    send_line("****** title");
    send_line("*******");
    send_line("**x");
    send_line({KW_OPEN, "_src c"});
    send_line({KW_CLOSE, "_src"});
    send_line({KW_OPEN, "_quote"});
    send_line({KW_CLOSE, "_quote"});
    send_line("#+begin_sr");
    send_line("#+title: x");
    send_line("#+:");
    send_line("#+");
    send_line("#:x");
    send_line("  - item");
    send_line("9.");
    send_line("  ");
    send_line("text");
  endtask

  // CR handling: dropped before a line end, kept anywhere else.
  task automatic test_carriage_return();
    send_req(8'h61, 1'b0);
    send_req(8'h62, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(CH_NL, 1'b0);
    send_req(8'h61, 1'b0);
    send_req(CH_CR, 1'b0);
    send_line("b");
    send_req(CH_CR, 1'b0);
    send_req(CH_NL, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(CH_NL, 1'b0);
    send_req(CH_STAR, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(CH_NL, 1'b0);
    send_req(CH_STAR, 1'b0);
    send_req(CH_CR, 1'b0);
    send_line(" x");
  endtask

  // NUL and the top byte values are ordinary characters.
  task automatic test_odd_bytes();
    send_req(8'h00, 1'b0);
    send_req(CH_NL, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'h80, 1'b0);
    send_req(8'h7F, 1'b0);
    send_req(8'h00, 1'b0);
    send_req(CH_NL, 1'b0);
  endtask

  // A heading far longer than every block-marker prefix.
  task automatic test_long_line();
    send_req(CH_STAR, 1'b0);
    send_req(CH_SPACE, 1'b0);
    repeat (200) send_req(8'h61, 1'b0);
    send_req(CH_NL, 1'b0);
  endtask

  // Random lines under one idling pattern. Halfway through, the sender holds off
  // until every owed token has been returned.
  task automatic test_random(input int items, input int idle_pct, input int stall_pct);
    int   start;
    logic paused;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = sent;
    paused         = 1'b0;
    while (sent - start < items) begin
      send_rand_line();
      if (!paused && sent - start >= items / 2) begin
        wait_idle();
        paused = 1'b1;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_end_of_input();
    test_line_classes();
    test_carriage_return();
    test_odd_bytes();
    wait_idle();
    test_long_line();
    wait_idle();
    test_random(PHASE_ITEMS, 0, 0);
    test_random(PHASE_ITEMS, 52, 0);
    test_random(PHASE_ITEMS, 0, 52);
    test_random(PHASE_ITEMS, 24, 24);
    send_end();
    wait_idle();
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
